/* design/u8dec_pkg.sv */
`default_nettype none
package u8dec_pkg;

	typedef enum logic [1:0] {
		KIND_CP  = 2'd0,
		KIND_ERR = 2'd1,
		KIND_END = 2'd2
	} kind_t;

	// results caused by one byte: flushed errors, then an optional tail result
	typedef struct packed {
		logic [1:0]  err_cnt;
		logic        tail_valid;
		kind_t       tail_kind;
		logic [20:0] tail_cp;
	} burst_t;

	localparam logic [7:0] MASK_CONT = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] MASK_PAY  = 8'h3F;
	localparam logic [7:0] MASK_L2   = 8'h1F;
	localparam logic [7:0] MASK_L3   = 8'h0F;
	localparam logic [7:0] MASK_L4   = 8'h07;

endpackage
`default_nettype wire

/* design/u8dec_in_if.sv */
`default_nettype none
interface u8dec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink   (input valid, input text_byte, output ready);
endinterface
`default_nettype wire

/* design/u8dec_out_if.sv */
`default_nettype none
interface u8dec_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [20:0] code_point;
	logic        last_of_run;

	modport source (output valid, output result_kind, output code_point, output last_of_run,
		input ready);
	modport sink   (input valid, input result_kind, input code_point, input last_of_run,
		output ready);
endinterface
`default_nettype wire

/* design/utf8_stream_decoder_unit.sv */
// channel  role    transaction
// text     sink    one byte of the string (text_byte)
// result   source  one result (result_kind, code_point, last_of_run)
//
// one byte is taken per cycle while the output register is empty or
// sending its last result; its results sit in one output register and
// drain one per cycle while result is ready (text waits meanwhile, only for error bursts)
// a byte that yields no result leaves the output register empty and never stalls text
// arst_n clears the decoder state and empties the output register
`default_nettype none
module utf8_stream_decoder_unit
	import u8dec_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	u8dec_in_if.sink   text,
	u8dec_out_if.source result
);

	burst_t      burst;
	logic        text_fire;
	logic        out_fire;
	logic        out_last;

	logic        buf_valid_q;
	logic [1:0]  err_cnt_q;
	logic        tail_valid_q;
	kind_t       tail_kind_q;
	logic [20:0] tail_cp_q;

	u8dec_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (text_fire),
		.text_byte (text.text_byte),
		.burst     (burst)
	);

	assign out_last  = (err_cnt_q == 2'd0) || (err_cnt_q == 2'd1 && !tail_valid_q);
	assign out_fire  = result.valid && result.ready;
	assign text.ready = !buf_valid_q || (out_last && result.ready);
	assign text_fire = text.valid && text.ready;

	assign result.valid       = buf_valid_q;
	assign result.result_kind = (err_cnt_q != 2'd0) ? KIND_ERR : tail_kind_q;
	assign result.code_point  = (err_cnt_q != 2'd0) ? 21'd0 : tail_cp_q;
	assign result.last_of_run = out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q  <= 1'b0;
			err_cnt_q    <= 2'd0;
			tail_valid_q <= 1'b0;
		end else if (text_fire) begin
			buf_valid_q  <= (burst.err_cnt != 2'd0) || burst.tail_valid;
			err_cnt_q    <= burst.err_cnt;
			tail_valid_q <= burst.tail_valid;
		end else if (out_fire) begin
			if (err_cnt_q != 2'd0) begin
				err_cnt_q <= err_cnt_q - 2'd1;
			end else begin
				tail_valid_q <= 1'b0;
			end
			if (out_last) begin
				buf_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_fire) begin
			tail_kind_q <= burst.tail_kind;
			tail_cp_q   <= burst.tail_cp;
		end
	end

endmodule
`default_nettype wire

/* design/u8dec_core.sv */
`default_nettype none
module u8dec_core
	import u8dec_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] text_byte,
	output burst_t          burst
);

	logic [23:0] held_q;
	logic [1:0]  needed_q;
	logic [1:0]  nheld_q;

	logic [23:0] held_d;
	logic [1:0]  needed_d;
	logic [1:0]  nheld_d;
	logic        is_cont;
	logic [20:0] cp_asm;
	logic [5:0]  pay;

	assign is_cont = (text_byte & MASK_CONT) == CONT_TAG;
	assign pay     = text_byte[5:0] & MASK_PAY[5:0];

	// code point from the held bytes and the final continuation byte
	always_comb begin
		case (nheld_q)
			2'd1:    cp_asm = {10'd0, held_q[4:0] & MASK_L2[4:0], pay};
			2'd2:    cp_asm = {5'd0, held_q[11:8] & MASK_L3[3:0], held_q[5:0], pay};
			2'd3:    cp_asm = {held_q[18:16] & MASK_L4[2:0], held_q[13:8], held_q[5:0], pay};
			default: cp_asm = {10'd0, held_q[4:0] & MASK_L2[4:0], pay};
		endcase
	end

	always_comb begin
		burst    = '{err_cnt: 2'd0, tail_valid: 1'b0, tail_kind: KIND_CP, tail_cp: 21'd0};
		held_d   = held_q;
		needed_d = needed_q;
		nheld_d  = nheld_q;
		if (needed_q != 2'd0 && is_cont) begin
			if (needed_q == 2'd1) begin
				burst.tail_valid = 1'b1;
				burst.tail_kind  = KIND_CP;
				burst.tail_cp    = cp_asm;
				held_d   = 24'd0;
				needed_d = 2'd0;
				nheld_d  = 2'd0;
			end else begin
				held_d   = {held_q[15:0], text_byte};
				nheld_d  = nheld_q + 2'd1;
				needed_d = needed_q - 2'd1;
			end
		end else begin
			// flush an open sequence, then treat the byte as a new lead
			burst.err_cnt = (needed_q != 2'd0) ? nheld_q : 2'd0;
			held_d   = 24'd0;
			needed_d = 2'd0;
			nheld_d  = 2'd0;
			case (text_byte) inside
				8'h00: begin
					burst.tail_valid = 1'b1;
					burst.tail_kind  = KIND_END;
				end
				[8'h01:8'h7F]: begin
					burst.tail_valid = 1'b1;
					burst.tail_kind  = KIND_CP;
					burst.tail_cp    = {14'd0, text_byte[6:0]};
				end
				[8'hC0:8'hDF]: begin
					held_d   = {16'd0, text_byte};
					nheld_d  = 2'd1;
					needed_d = 2'd1;
				end
				[8'hE0:8'hEF]: begin
					held_d   = {16'd0, text_byte};
					nheld_d  = 2'd1;
					needed_d = 2'd2;
				end
				[8'hF0:8'hF7]: begin
					held_d   = {16'd0, text_byte};
					nheld_d  = 2'd1;
					needed_d = 2'd3;
				end
				default: begin
					burst.tail_valid = 1'b1;
					burst.tail_kind  = KIND_ERR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 24'd0;
			needed_q <= 2'd0;
			nheld_q  <= 2'd0;
		end else if (accept) begin
			held_q   <= held_d;
			needed_q <= needed_d;
			nheld_q  <= nheld_d;
		end
	end

endmodule
`default_nettype wire
